[sv/sme_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the stack machine execute unit
package sme_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DEPTH_W = 10;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_ADD   = 3'd2,
        OP_SUB   = 3'd3,
        OP_SHL   = 3'd4,
        OP_SHR   = 3'd5,
        OP_DUP   = 3'd6,
        OP_SWAP  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [VALUE_W-1:0] push_value;
    } sme_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] result_value;
        logic [DEPTH_W-1:0] depth;
    } sme_out_t;

endpackage

[sv/stack_machine_execute_unit.sv]
`timescale 1ns / 1ps
// stack machine execute unit: data stack in block memory with a cached top register
//
//   channel | ports                    | word
//   --------+--------------------------+-------------------------------------
//   input   | s_valid s_ready s_data   | req_type, push_value
//   result  | m_valid m_ready m_data   | status, result_value, depth
//
// each word passes accept, which issues the memory read of the entry below
// the top, then execute, which uses the registered read data and writes
// back; no new word is accepted until the current one is done.
// reset empties the stack at once; memory contents are never cleared.
// a stalled result holds the unit in execute until the output register frees.
module stack_machine_execute_unit import sme_pkg::*; #(
    parameter int unsigned STACK_DEPTH = 512
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sme_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sme_out_t m_data
);

    localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

    // entries below the top live here; the top lives in tos_reg
    logic [VALUE_W-1:0] mem [STACK_DEPTH];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [VALUE_W-1:0] tos_reg, tos_next;
    logic [2:0]         op_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic               m_valid_reg, m_valid_next;
    sme_out_t           out_reg, out_next;

    logic               in_fire;
    logic               done;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [1:0]         status;
    logic [VALUE_W-1:0] res;
    logic [VALUE_W-1:0] nos;
    logic               cnt_zero, cnt_lt2, cnt_full;
    logic [CNT_W-1:0]   cnt_m1, cnt_m2;

    assign in_fire  = s_valid && s_ready;
    assign done     = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign rd_addr  = cnt_m2[ADDR_W-1:0];
    assign cnt_zero = (count_reg == '0);
    assign cnt_lt2  = (count_reg < CNT_W'(2));
    assign cnt_full = (count_reg >= CNT_W'(STACK_DEPTH));
    assign nos      = rd_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = aresetn;
            ST_EXEC: s_ready = 1'b0;
            default: s_ready = 1'b0;
        endcase
    end

    // execute: top in tos_reg, next-on-stack from the memory read
    always_comb begin
        count_next = count_reg;
        tos_next   = tos_reg;
        wr_en      = 1'b0;
        wr_addr    = cnt_m1[ADDR_W-1:0];
        wr_data    = tos_reg;
        status     = STAT_OK;
        res        = '0;
        case (op_t'(op_reg))
            OP_PUSH: begin
                if (cnt_full) begin
                    status = STAT_OVER;
                    res    = tos_reg;
                end else begin
                    wr_en      = !cnt_zero;
                    tos_next   = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    res        = val_reg;
                end
            end
            OP_POP: begin
                if (cnt_zero) begin
                    status = STAT_UNDER;
                end else begin
                    res        = tos_reg;
                    tos_next   = nos;
                    count_next = cnt_m1;
                end
            end
            OP_DUP: begin
                if (cnt_zero) begin
                    status = STAT_UNDER;
                end else if (cnt_full) begin
                    status = STAT_OVER;
                    res    = tos_reg;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    res        = tos_reg;
                end
            end
            OP_SWAP: begin
                if (cnt_lt2) begin
                    status = STAT_UNDER;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = cnt_m2[ADDR_W-1:0];
                    tos_next = nos;
                    res      = nos;
                end
            end
            default: begin
                if (cnt_lt2) begin
                    status = STAT_UNDER;
                end else begin
                    case (op_t'(op_reg))
                        OP_ADD: res = nos + tos_reg;
                        OP_SUB: res = nos - tos_reg;
                        OP_SHL: res = (|tos_reg[VALUE_W-1:5]) ? '0 : (nos << tos_reg[4:0]);
                        OP_SHR: res = (|tos_reg[VALUE_W-1:5]) ? '0 : (nos >> tos_reg[4:0]);
                        default: res = '0;
                    endcase
                    tos_next   = res;
                    count_next = cnt_m1;
                end
            end
        endcase
        if (status == STAT_UNDER) begin
            count_next = '0;
            res        = '0;
        end
    end

    always_comb begin
        out_next              = out_reg;
        m_valid_next          = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (done) begin
            m_valid_next          = 1'b1;
            out_next.status       = status;
            out_next.result_value = res;
            out_next.depth        = DEPTH_W'(count_next);
        end
    end

    // read issued only on accept, write only in execute: never the same cycle
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (done && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (done) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg  <= s_data.req_type;
            val_reg <= s_data.push_value;
        end
        if (done) begin
            tos_reg <= tos_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

[sv/sme_checker.sv]
`timescale 1ns / 1ps
// port checker for the stack machine execute unit and its bind
module sme_checker import sme_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input sme_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input sme_out_t m_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // one word in flight: busy in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STAT_OK || m_data.status == STAT_UNDER ||
                     m_data.status == STAT_OVER))
        else $error("undefined status code");

    // underflow empties the stack and returns zero
    a_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STAT_UNDER |->
            m_data.result_value == '0 && m_data.depth == '0)
        else $error("underflow result not cleared");

endmodule

bind stack_machine_execute_unit sme_checker u_sme_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
